[rtl/pfa_pkg.sv]
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int unsigned NUM_FRAMES_DEFAULT = 1024;
    localparam int unsigned FRAME_COUNT_RESET  = 1024;
    localparam int unsigned WORD_BITS          = 64;
    localparam int unsigned WORD_W             = 6;

    localparam int unsigned FRAME_W  = 21;
    localparam int unsigned BASE_W   = 20;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_QUERY   = 2'd2,
        MODE_RSVD    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STS_OK           = 2'd0,
        STS_NO_FREE      = 2'd1,
        STS_ALREADY_FREE = 2'd2,
        STS_OUT_OF_RANGE = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b1;

    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_SCAN = 1'b1
    } ctl_state_t;

    typedef enum logic [1:0] {
        SCAN_SEARCH = 2'd0,
        SCAN_RUN    = 2'd1,
        SCAN_DONE   = 2'd2
    } scan_phase_t;

    typedef struct packed {
        logic        valid;
        scan_phase_t phase;
    } scan_tok_t;

    typedef struct packed {
        logic reload;
        logic set_bit;
        logic clr_bit;
    } cell_cmd_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [FRAME_W-1:0] frame_number;
    } req_item_t;

    typedef struct packed {
        logic [FRAME_W-1:0] result_frame;
        logic [1:0]         status;
        logic               is_free;
        logic [COUNT_W-1:0] free_count;
    } rsp_item_t;

    // Free bits of one word whose first frame is base, for n managed frames.
    function automatic logic [WORD_BITS-1:0] free_mask(input int unsigned base,
                                                       input int unsigned n);
        logic [WORD_BITS-1:0] m;
        m = '0;
        for (int unsigned b = 0; b < WORD_BITS; b++) begin
            m[b] = ((base + b) < n);
        end
        return m;
    endfunction

    // One-hot to binary.
    function automatic logic [WORD_W-1:0] enc_onehot(input logic [WORD_BITS-1:0] v);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int unsigned b = 0; b < WORD_BITS; b++) begin
            if (v[b])
            begin
                r = r | WORD_W'(b);
            end
        end
        return r;
    endfunction

endpackage

[rtl/pfa_cell.sv]
`timescale 1ns / 1ps

// One 64-frame slice of the free bitmap plus one stage of the scan chain.
module pfa_cell #(
    parameter int unsigned ID          = 0,
    parameter int unsigned IDX_W       = 10,
    parameter int unsigned CNT_W       = 11,
    parameter int unsigned RESET_COUNT = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfa_pkg::cell_cmd_t   cmd,
    input  logic [IDX_W-1:0]     cmd_idx,
    input  logic [CNT_W-1:0]     reload_count,
    input  pfa_pkg::scan_tok_t   tok_in,
    input  logic [IDX_W-1:0]     end_in,
    output pfa_pkg::scan_tok_t   tok_out,
    output logic [IDX_W-1:0]     end_out,
    output logic                 bit_rd
);

    localparam int unsigned WB = pfa_pkg::WORD_BITS;
    localparam logic [IDX_W-1:0] CELL_BASE = IDX_W'(ID * WB);
    localparam logic [WB-1:0] RESET_MASK = pfa_pkg::free_mask(ID * WB, RESET_COUNT);

    logic [WB-1:0]                  word_reg, word_next;
    pfa_pkg::scan_tok_t             tok_reg, tok_next;
    logic [IDX_W-1:0]               end_reg, end_next;

    logic                           sel;
    logic [pfa_pkg::WORD_W-1:0]     bit_pos;
    logic [WB-1:0]                  low;
    logic [WB:0]                    sum;
    logic [WB-1:0]                  zhot;
    logic                           hit;

    assign sel     = ((cmd_idx >> pfa_pkg::WORD_W) == IDX_W'(ID));
    assign bit_pos = cmd_idx[pfa_pkg::WORD_W-1:0];
    assign bit_rd  = sel & word_reg[bit_pos];

    // Lowest free bit; adding it ripples through the run and lands on the
    // first used bit above it. Carry out means the run hits the top bit.
    assign low  = word_reg & (~word_reg + WB'(1));
    assign sum  = {1'b0, word_reg} + {1'b0, low};
    assign zhot = sum[WB-1:0] & ~word_reg;

    always_comb
    begin
        word_next = word_reg;
        if (cmd.reload)
        begin
            word_next = pfa_pkg::free_mask(ID * WB, int'(reload_count));
        end
        else
        begin
            if (cmd.set_bit && sel)
            begin
                word_next[bit_pos] = 1'b1;
            end
            if (cmd.clr_bit && sel)
            begin
                word_next[bit_pos] = 1'b0;
            end
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        end_next = end_in;
        hit      = 1'b0;
        if (tok_in.valid)
        begin
            unique case (tok_in.phase)
                pfa_pkg::SCAN_SEARCH: hit = (word_reg != '0);
                pfa_pkg::SCAN_RUN:
                begin
                    hit = word_reg[0];
                    if (!word_reg[0])
                    begin
                        tok_next.phase = pfa_pkg::SCAN_DONE;
                    end
                end
                pfa_pkg::SCAN_DONE: hit = 1'b0;
                default:            hit = 1'b0;
            endcase
            if (hit)
            begin
                if (sum[WB])
                begin
                    tok_next.phase = pfa_pkg::SCAN_RUN;
                    end_next       = CELL_BASE + IDX_W'(WB - 1);
                end
                else
                begin
                    tok_next.phase = pfa_pkg::SCAN_DONE;
                    end_next       = CELL_BASE + IDX_W'(pfa_pkg::enc_onehot(zhot >> 1));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= RESET_MASK;
            tok_reg  <= '0;
        end
        else
        begin
            word_reg <= word_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg <= end_next;
    end

    assign tok_out = tok_reg;
    assign end_out = end_reg;

endmodule

[rtl/physical_frame_allocator_core.sv]
`timescale 1ns / 1ps

// Physical frame allocator with a first-fit bitmap kept in a row of cells.
// Request channel (req_valid / req_stall / req): mode 0 allocates the last
// frame of the lowest free run, mode 1 releases a frame, mode 2 queries one
// frame, mode 3 is a no-op. Response channel (rsp_valid / rsp_stall / rsp)
// returns exactly one item per request, always with the free count.
// Timing: release, query and no-op results are registered straight into the
// response register, or the holding register while the receiver stalls. An
// allocate walks a scan token through all NUM_FRAMES/64 cells, one cell per
// cycle, then its result is registered; that walk is what sets allocate rate.
// One item is in flight at a time; a one-entry holding register behind the
// response register lets a finished item park while the receiver stalls,
// and req_stall stays high while that holding register is full.
// Config: cfg_index 0 is base_frame, 1 is frame_count; writing frame_count
// (low 11 bits of cfg_data, saturated to NUM_FRAMES) frees all managed frames at once.
// Reset: base 0, frame_count 1024 (capped), every managed frame free,
// no items in flight.
module physical_frame_allocator_core #(
    parameter int unsigned NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  pfa_pkg::req_item_t                req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output pfa_pkg::rsp_item_t                rsp,
    input  logic                              cfg_wr_en,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfa_pkg::BASE_W-1:0]        cfg_data
);

    localparam int unsigned WB        = pfa_pkg::WORD_BITS;
    localparam int unsigned NUM_CELLS = (NUM_FRAMES + WB - 1) / WB;
    localparam int unsigned IDX_W     = $clog2(NUM_CELLS * WB);
    localparam int unsigned CNT_W     = $clog2(NUM_FRAMES + 1);
    localparam int unsigned RESET_COUNT =
        (pfa_pkg::FRAME_COUNT_RESET > NUM_FRAMES) ? NUM_FRAMES : pfa_pkg::FRAME_COUNT_RESET;
    localparam int unsigned FW = pfa_pkg::FRAME_W;

    // control
    pfa_pkg::ctl_state_t           state_reg, state_next;
    logic [pfa_pkg::BASE_W-1:0]    base_reg, base_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              free_reg, free_next;

    // response register and holding slot
    logic                          rsp_valid_reg, rsp_valid_next;
    pfa_pkg::rsp_item_t            rsp_reg, rsp_next;
    logic                          pend_valid_reg, pend_valid_next;
    pfa_pkg::rsp_item_t            pend_reg, pend_next;

    // cell chain
    pfa_pkg::scan_tok_t            tok_chain [NUM_CELLS+1];
    logic [IDX_W-1:0]              end_chain [NUM_CELLS+1];
    logic [NUM_CELLS-1:0]          rd_bits;
    pfa_pkg::cell_cmd_t            cmd;
    logic [IDX_W-1:0]              cmd_idx;
    logic                          hit_bit;

    logic                          accept;
    logic                          out_free;
    logic [FW:0]                   off;
    logic                          in_range;
    logic [CNT_W-1:0]              cfg_count;
    logic                          res_valid;
    pfa_pkg::rsp_item_t            res;
    pfa_pkg::scan_tok_t            launch;
    pfa_pkg::scan_tok_t            tok_last;

    assign req_stall = (state_reg != pfa_pkg::CTL_IDLE) || pend_valid_reg;
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign tok_last  = tok_chain[NUM_CELLS];
    assign hit_bit   = |rd_bits;

    // Offset from base; top bit set means the frame lies below base.
    assign off      = {1'b0, req.frame_number} - {2'b0, base_reg};
    assign in_range = !off[FW] && (off < (FW+1)'(count_reg));

    assign cfg_count = (32'(cfg_data[pfa_pkg::COUNT_W-1:0]) > NUM_FRAMES)
                     ? CNT_W'(NUM_FRAMES) : CNT_W'(cfg_data[pfa_pkg::COUNT_W-1:0]);

    // Chain entry: a fresh token only on an accepted allocate.
    always_comb
    begin
        launch.valid = accept && (pfa_pkg::mode_t'(req.mode) == pfa_pkg::MODE_ALLOC);
        launch.phase = pfa_pkg::SCAN_SEARCH;
    end

    assign tok_chain[0] = launch;
    assign end_chain[0] = '0;

    // During a scan the broadcast index is the run end found by the chain.
    assign cmd_idx = (state_reg == pfa_pkg::CTL_SCAN) ? end_chain[NUM_CELLS] : off[IDX_W-1:0];

    for (genvar c = 0; c < NUM_CELLS; c++)
    begin : g_cell
        pfa_cell #(
            .ID          (c),
            .IDX_W       (IDX_W),
            .CNT_W       (CNT_W),
            .RESET_COUNT (RESET_COUNT)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .cmd_idx      (cmd_idx),
            .reload_count (cfg_count),
            .tok_in       (tok_chain[c]),
            .end_in       (end_chain[c]),
            .tok_out      (tok_chain[c+1]),
            .end_out      (end_chain[c+1]),
            .bit_rd       (rd_bits[c])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        count_next = count_reg;
        free_next  = free_reg;
        cmd        = '0;
        res_valid  = 1'b0;
        res        = '0;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                pfa_pkg::CFG_BASE_FRAME:  base_next = cfg_data;
                pfa_pkg::CFG_FRAME_COUNT:
                begin
                    count_next = cfg_count;
                    free_next  = cfg_count;
                    cmd.reload = 1'b1;
                end
                default: base_next = base_reg;
            endcase
        end

        unique case (state_reg)
            pfa_pkg::CTL_IDLE:
            begin
                if (accept)
                begin
                    unique case (pfa_pkg::mode_t'(req.mode))
                        pfa_pkg::MODE_ALLOC: state_next = pfa_pkg::CTL_SCAN;
                        pfa_pkg::MODE_RELEASE:
                        begin
                            res_valid = 1'b1;
                            if (!in_range)
                            begin
                                res.status = pfa_pkg::STS_OUT_OF_RANGE;
                            end
                            else if (hit_bit)
                            begin
                                res.status = pfa_pkg::STS_ALREADY_FREE;
                            end
                            else
                            begin
                                res.status  = pfa_pkg::STS_OK;
                                cmd.set_bit = 1'b1;
                                free_next   = free_reg + CNT_W'(1);
                            end
                        end
                        pfa_pkg::MODE_QUERY:
                        begin
                            res_valid = 1'b1;
                            if (!in_range)
                            begin
                                res.status = pfa_pkg::STS_OUT_OF_RANGE;
                            end
                            else
                            begin
                                res.status  = pfa_pkg::STS_OK;
                                res.is_free = hit_bit;
                            end
                        end
                        pfa_pkg::MODE_RSVD:
                        begin
                            res_valid  = 1'b1;
                            res.status = pfa_pkg::STS_OK;
                        end
                        default: res_valid = 1'b0;
                    endcase
                end
            end
            pfa_pkg::CTL_SCAN:
            begin
                if (tok_last.valid)
                begin
                    state_next = pfa_pkg::CTL_IDLE;
                    res_valid  = 1'b1;
                    if (tok_last.phase == pfa_pkg::SCAN_SEARCH)
                    begin
                        res.status = pfa_pkg::STS_NO_FREE;
                    end
                    else
                    begin
                        res.status       = pfa_pkg::STS_OK;
                        res.result_frame = FW'(base_reg) + FW'(end_chain[NUM_CELLS]);
                        cmd.clr_bit      = 1'b1;
                        free_next        = free_reg - CNT_W'(1);
                    end
                end
            end
            default: state_next = pfa_pkg::CTL_IDLE;
        endcase

        res.free_count = pfa_pkg::COUNT_W'(free_next);
    end

    // Response register fed first from the holding slot, else straight.
    always_comb
    begin
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (pend_valid_reg && out_free)
        begin
            rsp_next        = pend_reg;
            rsp_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
        if (res_valid)
        begin
            if (out_free && !pend_valid_reg)
            begin
                rsp_next       = res;
                rsp_valid_next = 1'b1;
            end
            else
            begin
                pend_next       = res;
                pend_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pfa_pkg::CTL_IDLE;
            base_reg       <= '0;
            count_reg      <= CNT_W'(RESET_COUNT);
            free_reg       <= CNT_W'(RESET_COUNT);
            rsp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            count_reg      <= count_next;
            free_reg       <= free_next;
            rsp_valid_reg  <= rsp_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        pend_reg <= pend_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

// Testbench for physical_frame_allocator_core.
// A shadow copy of the free map, the free total and both registers predicts
// every response item. Request items are driven at the falling edge and the
// response channel is sampled at the rising edge. The checker compares each
// accepted response with the oldest prediction, field by field.
module testbench;

    localparam int unsigned FRAMES      = pfa_pkg::NUM_FRAMES_DEFAULT;
    localparam int unsigned FW          = pfa_pkg::FRAME_W;
    localparam int unsigned BW          = pfa_pkg::BASE_W;
    localparam int unsigned CW          = pfa_pkg::COUNT_W;
    localparam int unsigned IW          = pfa_pkg::CFG_IDX_W;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    // An allocate walks every 64-frame word once; allow that plus margin.
    localparam int unsigned SETTLE      = FRAMES / 64 + 8;

    typedef enum int unsigned {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_pattern_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    pfa_pkg::req_item_t   req       = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    pfa_pkg::rsp_item_t   rsp;
    logic                 cfg_wr_en = 1'b0;
    logic [IW-1:0]        cfg_index = pfa_pkg::CFG_BASE_FRAME;
    logic [BW-1:0]        cfg_data  = '0;

    // Shadow allocator state
    bit                   shadow_free [FRAMES];
    int unsigned          shadow_total;
    logic [BW-1:0]        shadow_base;
    logic [CW-1:0]        shadow_count;

    pfa_pkg::rsp_item_t   expected_rsp_q [$];
    int unsigned          error_count = 0;
    int unsigned          cycle_count = 0;
    int unsigned          burst_left  = 0;
    int unsigned          gap_max     = 24;
    stall_pattern_t       stall_mode  = STALL_NONE;
    int unsigned          stall_left  = 0;

    physical_frame_allocator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Counts above the map size saturate; zero manages nothing.
    function automatic int unsigned managed_frames();
        return (shadow_count > FRAMES) ? FRAMES : int'(shadow_count);
    endfunction

    // Count write: every managed frame free, the rest not present.
    function automatic void reload_shadow();
        int unsigned n;
        n = managed_frames();
        for (int unsigned i = 0; i < FRAMES; i++)
        begin
            shadow_free[i] = (i < n);
        end
        shadow_total = n;
    endfunction

    // Absolute frame to managed slot; 0 when outside the window.
    function automatic bit frame_slot(input logic [FW-1:0] fnum,
                                      output int unsigned idx);
        longint unsigned off;
        idx = 0;
        if (fnum < shadow_base)
        begin
            return 1'b0;
        end
        off = longint'(fnum) - longint'(shadow_base);
        if (off >= managed_frames())
        begin
            return 1'b0;
        end
        idx = int'(off);
        return 1'b1;
    endfunction

    // Applies one request item to the shadow state and returns its response.
    function automatic pfa_pkg::rsp_item_t predict_allocation(input pfa_pkg::req_item_t it);
        pfa_pkg::rsp_item_t r;
        int unsigned        n;
        int unsigned        i;
        int unsigned        idx;
        r = '0;
        n = managed_frames();
        case (pfa_pkg::mode_t'(it.mode))
            pfa_pkg::MODE_ALLOC:
            begin
                // First free frame, then follow its run to the last free one.
                i = 0;
                while (i < n && !shadow_free[i])
                begin
                    i++;
                end
                if (i >= n)
                begin
                    r.status = pfa_pkg::STS_NO_FREE;
                end
                else
                begin
                    while (i + 1 < n && shadow_free[i + 1])
                    begin
                        i++;
                    end
                    shadow_free[i] = 1'b0;
                    shadow_total--;
                    r.result_frame = FW'(shadow_base + i);
                end
            end
            pfa_pkg::MODE_RELEASE:
            begin
                if (!frame_slot(it.frame_number, idx))
                begin
                    r.status = pfa_pkg::STS_OUT_OF_RANGE;
                end
                else if (shadow_free[idx])
                begin
                    r.status = pfa_pkg::STS_ALREADY_FREE;
                end
                else
                begin
                    shadow_free[idx] = 1'b1;
                    shadow_total++;
                end
            end
            pfa_pkg::MODE_QUERY:
            begin
                if (!frame_slot(it.frame_number, idx))
                begin
                    r.status = pfa_pkg::STS_OUT_OF_RANGE;
                end
                else
                begin
                    r.is_free = shadow_free[idx];
                end
            end
            default:
            begin
                // reserved mode: nothing changes
            end
        endcase
        r.free_count = CW'(shadow_total);
        return r;
    endfunction

    // Sends one request item. Called and returns at a falling edge; valid is
    // left high so the next item of a burst follows without a bubble.
    task automatic send_req(input pfa_pkg::mode_t mode, input logic [FW-1:0] fnum);
        pfa_pkg::req_item_t it;
        int unsigned        gap;
        it.mode         = mode;
        it.frame_number = fnum;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        req_valid <= 1'b1;
        req       <= it;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        expected_rsp_q.push_back(predict_allocation(it));
        @(negedge clk);
        burst_left--;
    endtask

    // Drops valid and waits until every predicted response has come back.
    task automatic wait_drained();
        req_valid  <= 1'b0;
        burst_left = 0;
        while (expected_rsp_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [IW-1:0] index,
                             input logic [BW-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (index == pfa_pkg::CFG_BASE_FRAME)
        begin
            shadow_base = value;
        end
        else
        begin
            shadow_count = CW'(value);
            reload_shadow();
        end
    endtask

    // Default window after reset: bounds, a double release, two allocates
    // from the tail of the single free run, reserved mode.
    task automatic test_reset_state();
        send_req(pfa_pkg::MODE_QUERY, 21'd0);
        send_req(pfa_pkg::MODE_QUERY, 21'd1023);
        send_req(pfa_pkg::MODE_QUERY, 21'd1024);
        send_req(pfa_pkg::MODE_QUERY, 21'h1FFFFF);
        send_req(pfa_pkg::MODE_RELEASE, 21'd5);
        send_req(pfa_pkg::MODE_ALLOC, 21'h1FFFFF);
        send_req(pfa_pkg::MODE_ALLOC, 21'd0);
        send_req(pfa_pkg::MODE_QUERY, 21'd1023);
        send_req(pfa_pkg::MODE_RELEASE, 21'd1023);
        send_req(pfa_pkg::MODE_RSVD, 21'h1FFFFF);
        send_req(pfa_pkg::MODE_RELEASE, 21'h1FFFFF);
        wait_drained();
    endtask

    // Highest base, an empty window, then an oversized count that saturates.
    task automatic test_config_extremes();
        cfg_write(pfa_pkg::CFG_BASE_FRAME, 20'hFFFFF);
        cfg_write(pfa_pkg::CFG_FRAME_COUNT, 20'd0);
        send_req(pfa_pkg::MODE_ALLOC, 21'd0);
        send_req(pfa_pkg::MODE_QUERY, 21'hFFFFF);
        send_req(pfa_pkg::MODE_RELEASE, 21'hFFFFF);
        wait_drained();
        cfg_write(pfa_pkg::CFG_FRAME_COUNT, 20'd2047);
        send_req(pfa_pkg::MODE_ALLOC, 21'd0);
        send_req(pfa_pkg::MODE_QUERY, 21'h1003FE);
        send_req(pfa_pkg::MODE_QUERY, 21'h1003FF);
        send_req(pfa_pkg::MODE_QUERY, 21'hFFFFE);
        wait_drained();
    endtask

    // Two-frame window: exhaust it, then a double release.
    task automatic test_small_window();
        cfg_write(pfa_pkg::CFG_BASE_FRAME, 20'd3);
        cfg_write(pfa_pkg::CFG_FRAME_COUNT, 20'd2);
        send_req(pfa_pkg::MODE_ALLOC, 21'd0);
        send_req(pfa_pkg::MODE_ALLOC, 21'd0);
        send_req(pfa_pkg::MODE_ALLOC, 21'd0);
        send_req(pfa_pkg::MODE_RELEASE, 21'd4);
        send_req(pfa_pkg::MODE_RELEASE, 21'd4);
        send_req(pfa_pkg::MODE_ALLOC, 21'd0);
        wait_drained();
    endtask

    // Random phases, each with its own window. Small windows fill up and
    // drain often, so most of the traffic lands on allocated frames.
    task automatic test_random_traffic();
        int unsigned        n;
        int unsigned        idx;
        int unsigned        s;
        int unsigned        pick;
        logic [BW-1:0]      new_base;
        logic [BW-1:0]      new_count;
        pfa_pkg::mode_t     mode;
        logic [FW-1:0]      fnum;
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0:       new_base = '0;
                1:       new_base = 20'hFFFFF;
                2:       new_base = BW'($urandom_range(0, 20'hFFFFF));
                default: new_base = BW'($urandom_range(0, 15));
            endcase
            case (ph)
                0:       new_count = 20'd1;
                1:       new_count = 20'd2;
                2:       new_count = BW'(FRAMES);
                3:       new_count = 20'd2047;
                4:       new_count = 20'd64;
                5:       new_count = BW'(FRAMES + 1);
                6:       new_count = 20'd3;
                7:       new_count = 20'd0;
                default: new_count = ($urandom_range(0, 3) == 0) ?
                                     BW'($urandom_range(1, FRAMES)) :
                                     BW'($urandom_range(1, 40));
            endcase
            cfg_write(pfa_pkg::CFG_BASE_FRAME, new_base);
            // Late phases sometimes keep the map and only move the window.
            if (ph < 8 || $urandom_range(0, 2) != 0)
            begin
                cfg_write(pfa_pkg::CFG_FRAME_COUNT, new_count);
            end
            gap_max = (ph % 3 == 1) ? 0 : 24;
            for (int j = 0; j < 160; j++)
            begin
                // Sender holds off once until the block has answered everything.
                if (ph == 4 && j == 80)
                begin
                    wait_drained();
                end
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    mode = pfa_pkg::MODE_ALLOC;
                end
                else if (pick < 80)
                begin
                    mode = pfa_pkg::MODE_RELEASE;
                end
                else if (pick < 95)
                begin
                    mode = pfa_pkg::MODE_QUERY;
                end
                else
                begin
                    mode = pfa_pkg::MODE_RSVD;
                end
                n    = managed_frames();
                pick = $urandom_range(0, 9);
                if (n != 0 && pick < 7)
                begin
                    idx = $urandom_range(0, n - 1);
                    // Half of the releases target a used frame when there is one.
                    if (mode == pfa_pkg::MODE_RELEASE && pick < 5)
                    begin
                        s = 0;
                        while (s < n && shadow_free[(idx + s) % n])
                        begin
                            s++;
                        end
                        if (s < n)
                        begin
                            idx = (idx + s) % n;
                        end
                    end
                    fnum = FW'(shadow_base + idx);
                end
                else if (pick == 7)
                begin
                    fnum = FW'(shadow_base - 1);
                end
                else if (pick == 8)
                begin
                    fnum = FW'(shadow_base + n + $urandom_range(0, 3));
                end
                else
                begin
                    fnum = FW'($urandom_range(0, 21'h1FFFFF));
                end
                send_req(mode, fnum);
            end
            wait_drained();
        end
    endtask

    initial
    begin
        shadow_base  = '0;
        shadow_count = CW'(pfa_pkg::FRAME_COUNT_RESET);
        reload_shadow();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_state();
        test_config_extremes();
        test_small_window();
        test_random_traffic();
        wait_drained();
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Receiver backpressure: patterns switch at random, including stretches
    // with no stall at all.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_pattern_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 200);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
            default:     rsp_stall <= ((stall_left % 8) < 3);
        endcase
    end

    function automatic void check_field(input string name,
                                        input logic [FW-1:0] want,
                                        input logic [FW-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : rsp_check
        pfa_pkg::rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $error("response item with none outstanding: frame %0h status %0d",
                       rsp.result_frame, rsp.status);
                error_count++;
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                check_field("result_frame", want.result_frame, rsp.result_frame);
                check_field("status", FW'(want.status), FW'(rsp.status));
                check_field("is_free", FW'(want.is_free), FW'(rsp.is_free));
                check_field("free_count", FW'(want.free_count), FW'(rsp.free_count));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule

[sim.f]
rtl/pfa_pkg.sv
rtl/pfa_cell.sv
rtl/physical_frame_allocator_core.sv
sim/testbench.sv
